[rtl/csc_pkg.sv]
// Shared types and constants for the crossfade switch controller.
// Depends on nothing; every other file of the block imports it.
package csc_pkg;

  // Field widths.
  localparam int unsigned DUR_W      = 24;  // transition duration
  localparam int unsigned CNT_W      = 4;   // source count
  localparam int unsigned MASK_W     = 8;   // connected mask
  localparam int unsigned REQ_W      = 8;   // requested index, signed
  localparam int unsigned EL_W       = 24;  // elapsed time per tick
  localparam int unsigned TIME_W     = 32;  // accumulated transition time
  localparam int unsigned PIN_W      = 3;   // mapped pin
  localparam int unsigned FRAC_W     = 24;  // Q0.24 easing ratio
  localparam int unsigned BF_W       = 17;  // Q1.16 blend factor
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Largest value the source count register can hold.
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK     = 2'd2;

  // Register values after reset.
  localparam logic [DUR_W-1:0]  DUR_RESET  = 24'd200000;
  localparam logic [CNT_W-1:0]  CNT_RESET  = 4'd2;
  localparam logic [MASK_W-1:0] MASK_RESET = 8'd3;

  // Blend factor of a settled output, and the rounding of the cubic term:
  // (4*r3 + 128) >> 8 equals (r3 + 32) >> 6.
  localparam logic [BF_W-1:0] BF_FULL     = 17'h10000;
  localparam int unsigned     ROUND_BIAS  = 32;
  localparam int unsigned     ROUND_SHIFT = 6;

  // Pins found by the source scan.
  typedef struct packed {
    logic [PIN_W-1:0] from_pin;
    logic [PIN_W-1:0] to_pin;
  } scan_res_t;

  // One result item.
  typedef struct packed {
    logic             valid_res;
    logic [PIN_W-1:0] from_pin;
    logic [PIN_W-1:0] to_pin;
    logic             blending;
    logic [BF_W-1:0]  blend_factor;
  } res_t;

endpackage

[rtl/csc_if.sv]
// Valid/ready channel interfaces of the crossfade switch controller:
// tick input, result output and configuration writes. Uses csc_pkg.
interface csc_tick_if import csc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [REQ_W-1:0] requested_index;
  logic [EL_W-1:0]         elapsed_us;

  modport source (output valid, requested_index, elapsed_us, input ready);
  modport sink   (input valid, requested_index, elapsed_us, output ready);
endinterface

interface csc_res_if import csc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [PIN_W-1:0] from_pin;
  logic [PIN_W-1:0] to_pin;
  logic             blending;
  logic [BF_W-1:0]  blend_factor;

  modport source (output valid, valid_res, from_pin, to_pin, blending, blend_factor,
                  input ready);
  modport sink   (input valid, valid_res, from_pin, to_pin, blending, blend_factor,
                  output ready);
endinterface

interface csc_cfg_if import csc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

[rtl/csc_pin_scan.sv]
// Serial source scan: maps the from and to indexes onto connected pins.
// One source is examined per cycle. Uses csc_pkg.
module csc_pin_scan import csc_pkg::*; #(
  parameter int unsigned IDX_W = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic [IDX_W-1:0]  from_idx_i,
  input  logic [IDX_W-1:0]  to_idx_i,
  output logic              done_o,
  output scan_res_t         pins_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] pos_q;
  logic [1:0]       fwd_hit_q, bwd_hit_q;
  logic [PIN_W-1:0] fwd_pin_q [2];
  logic [PIN_W-1:0] bwd_pin_q [2];
  logic [CNT_W-1:0] tgt [2];
  logic             conn;
  logic             last;

  // A source beyond the mask width is never connected.
  assign conn   = (pos_q < CNT_W'(MASK_W)) && mask_i[pos_q[PIN_W-1:0]];
  assign last   = (pos_q == count_i - CNT_W'(1));
  assign tgt[0] = CNT_W'(from_idx_i);
  assign tgt[1] = CNT_W'(to_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      pos_q     <= '0;
      fwd_hit_q <= '0;
      bwd_hit_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q    <= 1'b1;
        pos_q     <= '0;
        fwd_hit_q <= '0;
        bwd_hit_q <= '0;
      end else if (busy_q) begin
        for (int k = 0; k < 2; k++) begin
          if (conn) begin
            if (pos_q <= tgt[k]) begin
              fwd_hit_q[k] <= 1'b1;
            end else if (!bwd_hit_q[k]) begin
              bwd_hit_q[k] <= 1'b1;
            end
          end
        end
        pos_q <= pos_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Nearest connected source at or below the target wins; failing that,
  // the nearest one above it.
  always_ff @(posedge clk_i) begin
    if (busy_q && conn) begin
      for (int k = 0; k < 2; k++) begin
        if (pos_q <= tgt[k]) begin
          fwd_pin_q[k] <= pos_q[PIN_W-1:0];
        end else if (!bwd_hit_q[k]) begin
          bwd_pin_q[k] <= pos_q[PIN_W-1:0];
        end
      end
    end
  end

  assign done_o          = done_q;
  assign pins_o.from_pin = fwd_hit_q[0] ? fwd_pin_q[0] : bwd_pin_q[0];
  assign pins_o.to_pin   = fwd_hit_q[1] ? fwd_pin_q[1] : bwd_pin_q[1];

endmodule

[rtl/csc_div.sv]
// Restoring radix-2 divider giving floor(num * 2^24 / den) for num < den.
// One quotient bit per cycle. Uses csc_pkg.
module csc_div import csc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DUR_W-1:0]  num_i,
  input  logic [DUR_W-1:0]  den_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(FRAC_W);
  localparam logic [CW-1:0] LAST = CW'(FRAC_W - 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DUR_W-1:0]  rem_q;
  logic [DUR_W-1:0]  den_q;
  logic [FRAC_W-1:0] quot_q;
  logic [DUR_W:0]    shifted;
  logic              fits;

  // The remainder stays below the divisor, so it always fits DUR_W bits.
  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? DUR_W'(shifted - {1'b0, den_q}) : shifted[DUR_W-1:0];
      quot_q <= {quot_q[FRAC_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/csc_mul.sv]
// Shift-add multiplier giving (a * b) >> 24 for two Q0.24 operands.
// One multiplier bit per cycle, least significant first. Uses csc_pkg.
module csc_mul import csc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FRAC_W-1:0] a_i,
  input  logic [FRAC_W-1:0] b_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(FRAC_W);
  localparam logic [CW-1:0] LAST = CW'(FRAC_W - 1);

  logic                busy_q, done_q;
  logic [CW-1:0]       cnt_q;
  logic [FRAC_W-1:0]   a_q;
  logic [2*FRAC_W-1:0] prod_q;
  logic [FRAC_W:0]     sum;

  assign sum = {1'b0, prod_q[2*FRAC_W-1:FRAC_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{FRAC_W{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[FRAC_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q[2*FRAC_W-1:FRAC_W];

endmodule

[rtl/crossfade_switch_controller_top.sv]
// Top level of the crossfade switch controller: tick sequencer, state,
// configuration registers and result register. Uses csc_pkg, csc_if,
// csc_pin_scan, csc_div and csc_mul.
//
// Usage. Each transfer on tick_i carries a requested source index and the
// microseconds since the previous tick. For every tick exactly one result
// transfer follows on res_o with the mapped from and to pins and an
// ease-in-out-cubic blend factor in Q1.16. The cfg_i channel writes the
// duration, source count and connected mask; it is always ready, and it is
// meant to be written only while no tick is in flight.
// One tick is worked on at a time. A tick that settles on one source passes
// through the serial source scan (one source a cycle) before its result; a
// tick inside a fade then also goes through the bit-serial divider and two
// passes through the bit-serial multiplier, the square and then the cube.
// A tick with no connected source skips the scan and the arithmetic.
// Reset clears the fade state and loads the register defaults; no result
// is pending. When the receiver stalls, the finished result waits in the
// output register and the next tick is still taken; its own result then
// waits in the sequencer until the output register is free.
module crossfade_switch_controller_top import csc_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  csc_tick_if.sink  tick_i,
  csc_res_if.source res_o,
  csc_cfg_if.sink   cfg_i
);

  // The count register cannot name more sources than it can hold.
  localparam int unsigned NMAX  = (MAX_SOURCES < CNT_MAX) ? MAX_SOURCES : CNT_MAX;
  localparam int unsigned IDX_W = $clog2(NMAX);
  localparam logic [CNT_W-1:0] N_CAP = CNT_W'(NMAX);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_TIME   = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_SETTLE = 9'b000001000,
    ST_SCAN   = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_MUL_SQ = 9'b001000000,
    ST_MUL_CU = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DUR_W-1:0]  dur_q, dur_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MASK_W-1:0] mask_q, mask_d;

  // Fade state.
  logic              started_q, started_d;
  logic [IDX_W-1:0]  from_q, from_d;
  logic [IDX_W-1:0]  to_q, to_d;
  logic [TIME_W-1:0] time_q, time_d;

  // Per-tick working registers.
  logic signed [REQ_W-1:0] req_q, req_d;
  logic [EL_W-1:0]         el_q, el_d;
  logic [IDX_W-1:0]        dst_q, dst_d;
  logic                    first_q, first_d;
  logic                    blend_q, blend_d;
  logic [DUR_W-1:0]        u_q, u_d;
  res_t                    pend_q, pend_d;
  res_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // Datapath helpers.
  logic [CNT_W-1:0]  n_eff, n_m1;
  logic [MASK_W-1:0] used;
  logic              any_conn;
  logic [IDX_W-1:0]  dst, from_start, to_start, from_clamp, to_clamp;
  logic [TIME_W:0]   time_sum;
  logic [TIME_W-1:0] time_sat, dur_ext;
  logic              t_lt_d, two_t_lt_d;
  logic [BF_W-1:0]   f_val;
  logic [FRAC_W:0]   f_sum;

  // Unit handshakes.
  logic              scan_start, scan_done;
  scan_res_t         scan_pins;
  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quot;
  logic              mul_start, mul_done;
  logic [FRAC_W-1:0] mul_a, mul_b, mul_prod;

  // Sources in use and whether any of them is connected.
  assign n_eff = (cnt_q > N_CAP) ? N_CAP : cnt_q;
  assign n_m1  = n_eff - CNT_W'(1);
  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      used[j] = CNT_W'(j) < n_eff;
    end
  end
  assign any_conn = |(mask_q & used);

  // Requested index clamped to the sources in use.
  always_comb begin
    if (req_q[REQ_W-1]) begin
      dst = '0;
    end else if ({1'b0, req_q[REQ_W-2:0]} > REQ_W'(n_m1)) begin
      dst = n_m1[IDX_W-1:0];
    end else begin
      dst = req_q[IDX_W-1:0];
    end
  end

  // The first valid tick starts from the request; a stored index left
  // above the range by a smaller source count is pulled down to it.
  assign from_start = started_q ? from_q : dst;
  assign to_start   = started_q ? to_q : dst;
  assign from_clamp = (CNT_W'(from_start) > n_m1) ? n_m1[IDX_W-1:0] : from_start;
  assign to_clamp   = (CNT_W'(to_start) > n_m1) ? n_m1[IDX_W-1:0] : to_start;

  // Saturating time accumulation.
  assign time_sum = {1'b0, time_q} + (TIME_W + 1)'(el_q);
  assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

  assign dur_ext    = TIME_W'(dur_q);
  assign t_lt_d     = time_q < dur_ext;
  assign two_t_lt_d = {time_q, 1'b0} < (TIME_W + 1)'(dur_q);

  // Cubic term rounded to Q0.16, mirrored in the second half of the fade.
  assign f_sum = {1'b0, mul_prod} + (FRAC_W + 1)'(ROUND_BIAS);
  assign f_val = BF_W'(f_sum >> ROUND_SHIFT);

  always_comb begin
    state_d     = state_q;
    dur_d       = dur_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    started_d   = started_q;
    from_d      = from_q;
    to_d        = to_q;
    time_d      = time_q;
    req_d       = req_q;
    el_d        = el_q;
    dst_d       = dst_q;
    first_d     = first_q;
    blend_d     = blend_q;
    u_d         = u_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    scan_start  = 1'b0;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    mul_a       = div_quot;
    mul_b       = div_quot;

    if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        REG_DURATION: dur_d  = cfg_i.wdata[DUR_W-1:0];
        REG_COUNT:    cnt_d  = cfg_i.wdata[CNT_W-1:0];
        REG_MASK:     mask_d = cfg_i.wdata[MASK_W-1:0];
        default: ;
      endcase
    end

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (tick_i.valid) begin
          req_d   = tick_i.requested_index;
          el_d    = tick_i.elapsed_us;
          state_d = ST_TIME;
        end
      end
      ST_TIME: begin
        if (!any_conn) begin
          // Nothing to switch to: an all-zero result, state left alone.
          pend_d  = '0;
          state_d = ST_DONE;
        end else begin
          started_d = 1'b1;
          from_d    = from_clamp;
          to_d      = to_clamp;
          time_d    = time_sat;
          dst_d     = dst;
          state_d   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (dst_q != to_q) begin
          if (dst_q == from_q) begin
            // Back to the previous source: run the fade in reverse.
            from_d = to_q;
            to_d   = dst_q;
            time_d = t_lt_d ? dur_ext - time_q : '0;
          end else if (two_t_lt_d) begin
            // Early in the fade: only the target moves.
            to_d = dst_q;
          end else begin
            time_d = '0;
            from_d = to_q;
            to_d   = dst_q;
          end
        end
        state_d = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (!t_lt_d) begin
          from_d = to_q;
        end
        blend_d    = t_lt_d && (from_q != to_q);
        first_d    = two_t_lt_d;
        u_d        = two_t_lt_d ? time_q[DUR_W-1:0] : dur_q - time_q[DUR_W-1:0];
        scan_start = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          pend_d.valid_res = 1'b1;
          if (blend_q) begin
            pend_d.from_pin = scan_pins.from_pin;
            pend_d.to_pin   = scan_pins.to_pin;
            pend_d.blending = 1'b1;
            div_start       = 1'b1;
            state_d         = ST_DIV;
          end else begin
            pend_d.from_pin     = scan_pins.to_pin;
            pend_d.to_pin       = scan_pins.to_pin;
            pend_d.blending     = 1'b0;
            pend_d.blend_factor = BF_FULL;
            state_d             = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          mul_a     = mul_prod;
          mul_b     = div_quot;
          mul_start = 1'b1;
          state_d   = ST_MUL_CU;
        end
      end
      ST_MUL_CU: begin
        if (mul_done) begin
          pend_d.blend_factor = first_q ? f_val : BF_FULL - f_val;
          state_d             = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dur_q       <= DUR_RESET;
      cnt_q       <= CNT_RESET;
      mask_q      <= MASK_RESET;
      started_q   <= 1'b0;
      from_q      <= '0;
      to_q        <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dur_q       <= dur_d;
      cnt_q       <= cnt_d;
      mask_q      <= mask_d;
      started_q   <= started_d;
      from_q      <= from_d;
      to_q        <= to_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    el_q    <= el_d;
    dst_q   <= dst_d;
    first_q <= first_d;
    blend_q <= blend_d;
    u_q     <= u_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  csc_pin_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .count_i    (n_eff),
    .mask_i     (mask_q),
    .from_idx_i (from_q),
    .to_idx_i   (to_q),
    .done_o     (scan_done),
    .pins_o     (scan_pins)
  );

  csc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (u_q),
    .den_i   (dur_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  csc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign tick_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign res_o.valid        = out_valid_q;
  assign res_o.valid_res    = out_q.valid_res;
  assign res_o.from_pin     = out_q.from_pin;
  assign res_o.to_pin       = out_q.to_pin;
  assign res_o.blending     = out_q.blending;
  assign res_o.blend_factor = out_q.blend_factor;

endmodule

[tb/sv/csc_checker.sv]
// Scoreboard for the crossfade switch controller: watches the tick, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on csc_pkg and the channel interfaces in csc_if.
module csc_checker import csc_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  csc_tick_if         tick_mon,
  csc_res_if          res_mon,
  csc_cfg_if          cfg_mon,
  output int unsigned fails_o,
  output int unsigned pending_o,
  output int unsigned ticks_o,
  output int unsigned fading_o,
  output int unsigned dead_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHOWN_FAILS = 10;

  // Register copies.
  logic [DUR_W-1:0]  dur_q;
  logic [CNT_W-1:0]  count_q;
  logic [MASK_W-1:0] mask_q;

  // Fade state.
  logic              started_q;
  logic [PIN_W-1:0]  from_q;
  logic [PIN_W-1:0]  to_q;
  logic [TIME_W-1:0] time_q;

  res_t blend_q[$];

  function automatic logic src_up(int unsigned src);
    return (src < MASK_W) && mask_q[src];
  endfunction

  function automatic logic [BF_W-1:0] ease_cubic(logic [63:0] t, logic [63:0] d);
    logic        first;
    logic [63:0] u, r, r2, r3, f;
    first = (t << 1) < d;
    u  = first ? t : d - t;
    r  = (u << FRAC_W) / d;
    r2 = (r * r) >> FRAC_W;
    r3 = (r2 * r) >> FRAC_W;
    f  = (4 * r3 + 128) >> 8;
    return first ? f[BF_W-1:0] : BF_FULL - f[BF_W-1:0];
  endfunction

  // Works out the result of one tick and advances the fade state.
  function automatic res_t next_blend(logic signed [REQ_W-1:0] req, logic [EL_W-1:0] el);
    res_t             r;
    int unsigned      pin_map[MAX_SOURCES];
    int unsigned      n;
    int               req_i;
    logic [PIN_W-1:0] dst;
    logic [32:0]      sum;
    logic [63:0]      d;
    r = '0;
    d = 64'(dur_q);
    n = (count_q > MAX_SOURCES) ? MAX_SOURCES : count_q;
    if (n == 0) return r;
    for (int unsigned i = 0; i < n; i++) pin_map[i] = i;
    // Holes take the pin of the source below, then of the source above.
    for (int unsigned i = 1; i < n; i++)
      if (!src_up(pin_map[i])) pin_map[i] = pin_map[i-1];
    for (int unsigned i = n; i > 1; i--)
      if (!src_up(pin_map[i-2])) pin_map[i-2] = pin_map[i-1];
    if (!src_up(pin_map[0])) return r;

    req_i = int'(req);
    if (req_i < 0) dst = '0;
    else if (req_i > int'(n) - 1) dst = PIN_W'(n - 1);
    else dst = PIN_W'(req_i);

    if (!started_q) begin
      started_q = 1'b1;
      from_q = dst;
      to_q = dst;
    end
    if (to_q > n - 1) to_q = PIN_W'(n - 1);
    if (from_q > n - 1) from_q = PIN_W'(n - 1);

    sum = 33'(time_q) + 33'(el);
    time_q = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    if (dst != to_q) begin
      if (dst == from_q) begin
        // Back to where the fade came from: run it in reverse.
        from_q = to_q;
        to_q = dst;
        time_q = (time_q < d) ? 32'(d - time_q) : '0;
      end else if ((64'(time_q) << 1) < d) begin
        to_q = dst;
      end else begin
        time_q = '0;
        from_q = to_q;
        to_q = dst;
      end
    end
    if (time_q >= d) from_q = to_q;

    r.valid_res = 1'b1;
    r.to_pin = PIN_W'(pin_map[to_q]);
    if (from_q == to_q) begin
      r.from_pin = r.to_pin;
      r.blending = 1'b0;
      r.blend_factor = BF_FULL;
    end else begin
      r.from_pin = PIN_W'(pin_map[from_q]);
      r.blending = 1'b1;
      r.blend_factor = ease_cubic(64'(time_q), d);
    end
    return r;
  endfunction

  task automatic note_fail(string what, res_t want, res_t got);
    fails_o++;
    if (fails_o <= SHOWN_FAILS) begin
      $display("%0t: %s: expected valid=%0b from=%0d to=%0d blending=%0b factor=%0d",
               $time, what, want.valid_res, want.from_pin, want.to_pin, want.blending,
               want.blend_factor);
      $display("%0t: %s: actual   valid=%0b from=%0d to=%0d blending=%0b factor=%0d",
               $time, what, got.valid_res, got.from_pin, got.to_pin, got.blending,
               got.blend_factor);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      dur_q = DUR_RESET;
      count_q = CNT_RESET;
      mask_q = MASK_RESET;
      started_q = 1'b0;
      from_q = '0;
      to_q = '0;
      time_q = '0;
      blend_q.delete();
      fails_o = 0;
      ticks_o = 0;
      fading_o = 0;
      dead_o = 0;
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.valid_res = res_mon.valid_res;
        got.from_pin = res_mon.from_pin;
        got.to_pin = res_mon.to_pin;
        got.blending = res_mon.blending;
        got.blend_factor = res_mon.blend_factor;
        if (blend_q.size() == 0) begin
          note_fail("result with nothing outstanding", '0, got);
        end else begin
          want = blend_q.pop_front();
          if (got.valid_res !== want.valid_res || got.from_pin !== want.from_pin ||
              got.to_pin !== want.to_pin || got.blending !== want.blending ||
              got.blend_factor !== want.blend_factor)
            note_fail("result mismatch", want, got);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_idx)
          REG_DURATION: dur_q = cfg_mon.wdata[DUR_W-1:0];
          REG_COUNT:    count_q = cfg_mon.wdata[CNT_W-1:0];
          REG_MASK:     mask_q = cfg_mon.wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) begin
        want = next_blend(tick_mon.requested_index, tick_mon.elapsed_us);
        blend_q.push_back(want);
        ticks_o++;
        if (want.blending) fading_o++;
        if (!want.valid_res) dead_o++;
      end
      pending_o <= blend_q.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Top of the crossfade switch controller testbench: clock, reset, stimulus on
// the tick and configuration channels, result back-pressure and the verdict.
// Depends on csc_pkg, csc_if, crossfade_switch_controller_top and csc_checker.
module tb import csc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SRC      = 8;
  localparam time         CLK_PERIOD   = 10ns;
  localparam int unsigned RESET_CYCLES = 5;
  // Percentage of cycles in which the sender holds back or the receiver stalls.
  localparam int unsigned IDLE_PCT     = 26;
  // A fading tick ends well within the stall limit, so a stretch that long without
  // a single transfer on any channel can only mean the block has hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned SAT_ITEMS    = 270;
  // Register index that the block does not implement; a write to it must be
  // harmless.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [DUR_W-1:0]     DUR_TOP    = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;

  int unsigned fails, pending, ticks, fading, dead;
  int unsigned settings_cnt;

  csc_tick_if tick_if ();
  csc_res_if  res_if ();
  csc_cfg_if  cfg_if ();

  crossfade_switch_controller_top #(.MAX_SOURCES(MAX_SRC)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  csc_checker #(.MAX_SOURCES(MAX_SRC)) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_mon  (tick_if),
    .res_mon   (res_if),
    .cfg_mon   (cfg_if),
    .fails_o   (fails),
    .pending_o (pending),
    .ticks_o   (ticks),
    .fading_o  (fading),
    .dead_o    (dead)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The receiver stalls at random, except during the calm stretches where it
  // takes every result as soon as it is offered.
  always @(posedge clk_i) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: any transfer on any channel restarts the quiet count, and the run is
  // abandoned when that count reaches the stall limit.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one tick and returns at the edge of its transfer. Valid is left
  // high, so that a following tick can go out back to back; it is lowered only
  // when the sender holds back or when drain stops sending.
  task automatic send_tick(logic signed [REQ_W-1:0] req, logic [EL_W-1:0] el);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.requested_index <= req;
    tick_if.elapsed_us <= el;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // Stops sending and waits until every result owed has been transferred.
  // The first edge is always waited for, so that a tick taken at the current
  // edge has already been counted by the checker.
  task automatic drain();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Writes all three registers (and the unused index if poke_unused is set). The unused
  // upper bits of the count and mask writes carry random junk, which the block has to ignore.
  task automatic configure(logic [DUR_W-1:0] dur, logic [CNT_W-1:0] cnt,
                           logic [MASK_W-1:0] mask, bit poke_unused = 1'b0);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_write(REG_DURATION, dur);
    cfg_write(REG_COUNT, {junk[CFG_DATA_W-1:CNT_W], cnt});
    junk = CFG_DATA_W'($urandom);
    cfg_write(REG_MASK, {junk[CFG_DATA_W-1:MASK_W], mask});
    if (poke_unused) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    settings_cnt++;
  endtask

  // Requests mostly hold, go back to the previous source (a reversal) or pick
  // another source in range; the rest are raw bytes that exercise the clamp.
  function automatic logic signed [REQ_W-1:0] pick_request(int unsigned n,
      logic signed [REQ_W-1:0] last, logic signed [REQ_W-1:0] older);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return last;
    if (roll < 65) return older;
    if (roll < 85) return REQ_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    return REQ_W'($urandom);
  endfunction

  // Elapsed times are scaled to the fade length so that fades are crossed in
  // several ticks, with zeros and full-range values mixed in.
  function automatic logic [EL_W-1:0] pick_elapsed(int unsigned dur);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return EL_W'($urandom);
    if (roll < 30) return EL_W'($urandom_range(0, dur));
    return EL_W'($urandom_range(0, dur / 6 + 1));
  endfunction

  // Sets the receiver's stall mode for the phase; it stays so until the next
  // phase or section changes it.
  task automatic random_phase(logic [DUR_W-1:0] dur, logic [CNT_W-1:0] cnt,
                              logic [MASK_W-1:0] mask, bit quiet);
    int unsigned             n;
    logic signed [REQ_W-1:0] req, last, older;
    calm <= quiet;
    configure(dur, cnt, mask);
    n = (cnt > MAX_SRC) ? MAX_SRC : cnt;
    last = REQ_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    older = REQ_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    repeat (PHASE_ITEMS) begin
      req = pick_request(n, last, older);
      if (req != last) begin
        older = last;
        last = req;
      end
      send_tick(req, pick_elapsed(32'(dur)));
    end
    drain();
  endtask

  initial begin : stimulus
    logic [DUR_W-1:0]  dur;
    logic [CNT_W-1:0]  cnt;
    logic [MASK_W-1:0] mask;

    // Every input of the block is defined from the first instant.
    rst_ni = 1'b0;
    calm = 1'b0;
    settings_cnt = 0;
    tick_if.valid = 1'b0;
    tick_if.requested_index = '0;
    tick_if.elapsed_us = '0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_idx = REG_DURATION;
    cfg_if.wdata = '0;
    res_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With the reset settings (two sources, both connected)
    // the very first tick fixes both indices, then a restart, a step into the
    // fade, a reversal and a settle follow; requests at both ends of the byte
    // exercise the clamp.
    send_tick(1, 0);
    send_tick(127, DUR_TOP);
    send_tick(-128, 30000);
    send_tick(0, 40000);
    send_tick(1, 20000);
    send_tick(1, 0);
    send_tick(1, 200000);
    drain();

    // Four sources with only the outer two connected, so the middle ones are
    // filled from below. Retarget early in a fade, restart late in one, then
    // reverse; the spare register index is written once on the way.
    configure(200000, 4, 8'h09, 1'b1);
    send_tick(3, 0);
    send_tick(2, 50000);
    send_tick(1, 60000);
    send_tick(2, 10000);
    send_tick(3, 500000);
    send_tick(3, DUR_TOP);
    drain();

    // Shrinking the count leaves the stored indices out of range.
    configure(1000, 2, 8'h03);
    send_tick(1, 0);
    send_tick(0, 400);
    drain();

    // Nothing connected, then no sources at all: the result is all zero.
    configure(1000, 2, 8'h00);
    send_tick(0, 5);
    drain();
    configure(1000, 0, 8'hFF);
    send_tick(5, 5);
    drain();

    // Count beyond the supported maximum, only the top source connected, so
    // every hole is filled from above.
    configure(1000, 15, 8'h80);
    send_tick(7, 100);
    send_tick(100, 100);
    send_tick(0, 100);
    drain();

    // Zero fade length: every switch is immediate.
    configure(0, 8, 8'h5A);
    send_tick(3, 0);
    send_tick(6, 24'h123456);
    send_tick(3, 0);
    drain();

    // Random part: a few fixed corners of the register space, then random
    // settings. The second phase runs with no idling on either side.
    random_phase(200000, 2, 8'h03, 1'b0);
    random_phase(1000, 8, MASK_W'($urandom), 1'b1);
    random_phase(DUR_TOP, 5, 8'hFF, 1'b0);
    random_phase(1, 3, 8'h07, 1'b0);
    random_phase(0, 4, 8'h0A, 1'b0);
    repeat (5) begin
      dur = $urandom_range(0, 1) ? DUR_W'($urandom_range(1, 5000)) : DUR_W'($urandom);
      cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(0, 15))
                                        : CNT_W'($urandom_range(1, 8));
      mask = ($urandom_range(0, 3) == 0) ? 8'hFF : MASK_W'($urandom);
      random_phase(dur, cnt, mask, 1'b0);
    end

    // Holding one request with the longest step lets the accumulated time
    // reach its ceiling; switches afterwards start from a saturated time.
    calm <= 1'b1;
    configure(DUR_TOP, 3, 8'h05);
    repeat (SAT_ITEMS) send_tick(2, DUR_TOP);
    send_tick(1, 5);
    send_tick(2, 5);
    send_tick(-5, DUR_TOP);
    drain();
    calm <= 1'b0;

    // Let the block run on a little so that a stray late result is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d ticks under %0d register settings.", ticks, settings_cnt);
    $display("Of the expected results %0d were mid-fade and %0d had no source connected.",
             fading, dead);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results still outstanding.", fails, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
